### hw/rtl/sensor_response_frame_receiver_defines.svh
// assertion macros for the frame receiver checker
`ifndef SENSOR_RESPONSE_FRAME_RECEIVER_DEFINES_SVH
`define SENSOR_RESPONSE_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define SRFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srfr check failed");

// next-cycle implication, quiet while reset is asserted
`define SRFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srfr check failed");

`endif

### hw/rtl/srfr_pkg.sv
// types and constants of the sensor response frame receiver
`timescale 1ns / 1ps

package srfr_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] CMD_CODE   = 8'h86;
    localparam int unsigned FRAME_LEN = 9;

    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CMD   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LOW   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CMD = 2'd1,
        ST_BAD_SUM = 2'd2
    } status_t;

endpackage

### hw/rtl/sensor_response_frame_receiver.sv
// gas sensor response frame receiver: byte stream in, one status item per frame out
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------
//  rx      | rx_valid, rx_stall | rx_byte[7:0]
//  res     | res_valid, res_stall | frame_status[1:0], concentration[15:0]
//
// one byte accepted per cycle while rx_stall is low; a byte passes an input register, then the
// frame logic, and a checksum byte goes on into the result register
// asynchronous active-low reset returns to waiting for a start byte
// rx_stall rises only when a checksum byte meets a full result register that is stalled
// bytes that complete no frame never wait on the result side
`timescale 1ns / 1ps

module sensor_response_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  frame_status,
    output logic [15:0] concentration
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // frame state
    logic [srfr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic       cmd_ok_reg, cmd_ok_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;

    // result register
    logic              res_valid_reg, res_valid_next;
    srfr_pkg::status_t status_reg, status_next;
    logic [15:0]       conc_reg, conc_next;

    logic       waiting;
    logic       produce;
    logic       advance;
    logic [7:0] expect_sum;

    always_comb
    begin
        waiting    = (pos_reg == srfr_pkg::POS_IDLE) ||
                     (pos_reg inside {[srfr_pkg::FRAME_LEN : (1 << srfr_pkg::POS_W) - 1]});
        produce    = in_valid_reg && !waiting && (pos_reg == srfr_pkg::POS_CHECK);
        advance    = !produce || !res_valid_reg || !res_stall;
        expect_sum = 8'(~sum_reg + 8'd1);
    end

    assign rx_stall = !advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
        begin
            in_valid_next = rx_valid;
        end
    end

    // frame tracking on the byte held in the input register
    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cmd_ok_next = cmd_ok_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        if (in_valid_reg && advance)
        begin
            if (waiting)
            begin
                if (in_byte_reg == srfr_pkg::START_BYTE)
                begin
                    pos_next    = srfr_pkg::POS_CMD;
                    sum_next    = 8'd0;
                    cmd_ok_next = 1'b0;
                end
                else
                begin
                    pos_next = srfr_pkg::POS_IDLE;
                end
            end
            else if (pos_reg == srfr_pkg::POS_CHECK)
            begin
                pos_next = srfr_pkg::POS_IDLE;
            end
            else
            begin
                sum_next = 8'(sum_reg + in_byte_reg);
                pos_next = srfr_pkg::POS_W'(pos_reg + srfr_pkg::POS_W'(1));
                case (pos_reg)
                    srfr_pkg::POS_CMD:  cmd_ok_next = (in_byte_reg == srfr_pkg::CMD_CODE);
                    srfr_pkg::POS_HIGH: high_next   = in_byte_reg;
                    srfr_pkg::POS_LOW:  low_next    = in_byte_reg;
                    default:            ;
                endcase
            end
        end
    end

    // result: wrong command wins over checksum mismatch
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        status_next    = status_reg;
        conc_next      = conc_reg;
        if (produce && advance)
        begin
            res_valid_next = 1'b1;
            if (!cmd_ok_reg)
            begin
                status_next = srfr_pkg::ST_BAD_CMD;
                conc_next   = 16'd0;
            end
            else if (in_byte_reg != expect_sum)
            begin
                status_next = srfr_pkg::ST_BAD_SUM;
                conc_next   = 16'd0;
            end
            else
            begin
                status_next = srfr_pkg::ST_OK;
                conc_next   = {high_reg, low_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= srfr_pkg::POS_IDLE;
            sum_reg       <= 8'd0;
            cmd_ok_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            cmd_ok_reg    <= cmd_ok_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        high_reg   <= high_next;
        low_reg    <= low_next;
        status_reg <= status_next;
        conc_reg   <= conc_next;
    end

    assign res_valid     = res_valid_reg;
    assign frame_status  = status_reg;
    assign concentration = conc_reg;

endmodule

### hw/rtl/srfr_checker.sv
// port-level checks for the frame receiver and their bind
`timescale 1ns / 1ps
`include "sensor_response_frame_receiver_defines.svh"

module srfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_stall,
    input logic [7:0]  rx_byte,
    input logic        res_valid,
    input logic        res_stall,
    input logic [1:0]  frame_status,
    input logic [15:0] concentration
);

    // input side backs up only behind a blocked result
    `SRFR_ASSERT_NOW(a_stall_cause, clk, rst_n, rx_stall, res_valid && res_stall)

    // failed frames carry no concentration
    `SRFR_ASSERT_NOW(a_fail_zero, clk, rst_n,
        res_valid && (frame_status != srfr_pkg::ST_OK), concentration == 16'd0)

    // a stalled result holds
    `SRFR_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall,
        res_valid && $stable(frame_status) && $stable(concentration))

    // a stalled input item holds
    `SRFR_ASSERT_NEXT(a_rx_hold, clk, rst_n, rx_valid && rx_stall,
        rx_valid && $stable(rx_byte))

    // no result straight out of reset
    `SRFR_ASSERT_NEXT(a_reset_quiet, clk, rst_n, !$past(rst_n), !res_valid)

endmodule

bind sensor_response_frame_receiver srfr_checker u_srfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .frame_status  (frame_status),
    .concentration (concentration)
);

### tb/sv/sensor_response_frame_receiver_tb.sv
// testbench for the sensor response frame receiver: byte stream driver, result checker
`timescale 1ns / 1ps

module sensor_response_frame_receiver_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_BYTES = 850;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] data;
        bit         hold;
    } rx_item_t;

    typedef struct {
        srfr_pkg::status_t status;
        logic [15:0]       level;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  frame_status;
    logic [15:0] concentration;

    rx_item_t      rx_pending[$];
    frame_result_t results_due[$];

    int rx_total = 1;
    int rx_accepted = 0;
    int error_count = 0;
    int cycle_count = 0;

    // frame tracker state
    logic [srfr_pkg::POS_W-1:0] frame_pos = srfr_pkg::POS_IDLE;
    logic [7:0]                 frame_sum = 8'h00;
    bit                         cmd_ok = 1'b0;
    logic [7:0]                 level_hi = 8'h00;
    logic [7:0]                 level_lo = 8'h00;

    sensor_response_frame_receiver uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .frame_status  (frame_status),
        .concentration (concentration)
    );

    always #10 clk = ~clk;

    // advance the frame tracker by one accepted byte, queue a result on the checksum byte
    task automatic track_rx_byte(input logic [7:0] b);
        frame_result_t r;
        logic [7:0]    want_sum;
        if (frame_pos == srfr_pkg::POS_IDLE || frame_pos >= srfr_pkg::FRAME_LEN)
        begin
            if (b == srfr_pkg::START_BYTE)
            begin
                frame_pos = srfr_pkg::POS_CMD;
                frame_sum = 8'h00;
                cmd_ok    = 1'b0;
            end
            else
                frame_pos = srfr_pkg::POS_IDLE;
        end
        else if (frame_pos < srfr_pkg::POS_CHECK)
        begin
            frame_sum = frame_sum + b;
            if (frame_pos == srfr_pkg::POS_CMD)
                cmd_ok = (b == srfr_pkg::CMD_CODE);
            else if (frame_pos == srfr_pkg::POS_HIGH)
                level_hi = b;
            else if (frame_pos == srfr_pkg::POS_LOW)
                level_lo = b;
            frame_pos = frame_pos + 1'b1;
        end
        else
        begin
            want_sum = 8'h00 - frame_sum;
            r.level  = 16'h0000;
            if (!cmd_ok)
                r.status = srfr_pkg::ST_BAD_CMD;
            else if (b != want_sum)
                r.status = srfr_pkg::ST_BAD_SUM;
            else
            begin
                r.status = srfr_pkg::ST_OK;
                r.level  = {level_hi, level_lo};
            end
            results_due.push_back(r);
            frame_pos = srfr_pkg::POS_IDLE;
        end
    endtask

    task automatic queue_byte(input logic [7:0] data, input bit hold);
        rx_item_t it;
        it.data = data;
        it.hold = hold;
        rx_pending.push_back(it);
    endtask

    // start byte, command, level, four filler bytes, checksum (optionally corrupted)
    task automatic queue_frame(input logic [7:0] cmd, input logic [15:0] level,
                               input bit sum_ok, input bit hold);
        logic [7:0] s;
        logic [7:0] b;
        logic [7:0] ck;
        queue_byte(srfr_pkg::START_BYTE, hold);
        queue_byte(cmd, 1'b0);
        queue_byte(level[15:8], 1'b0);
        queue_byte(level[7:0], 1'b0);
        s = cmd + level[15:8] + level[7:0];
        for (int k = 4; k < 8; k++)
        begin
            b = 8'($urandom);
            s = s + b;
            queue_byte(b, 1'b0);
        end
        ck = 8'h00 - s;
        if (!sum_ok)
            ck = ck + 8'($urandom_range(1, 255));
        queue_byte(ck, 1'b0);
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic int idle_pct(input bit sender);
        int ph;
        ph = (rx_accepted * 3) / rx_total;
        if (ph == 0)
            return sender ? 23 : 59;
        else if (ph == 1)
            return sender ? 59 : 23;
        return 0;
    endfunction

    // driver
    always @(posedge clk)
    begin
        bit accepted;
        bit may_send;
        if (!rst_n)
            rx_valid <= 1'b0;
        else
        begin
            accepted = rx_valid && !rx_stall;
            if (accepted)
            begin
                track_rx_byte(rx_byte);
                rx_accepted++;
            end
            may_send = rx_pending.size() > 0;
            if (may_send && rx_pending[0].hold && results_due.size() > 0)
                may_send = 1'b0;
            if (rx_valid && !accepted)
                ;
            else if (may_send && $urandom_range(99) >= idle_pct(1'b1))
            begin
                rx_valid <= 1'b1;
                rx_byte  <= rx_pending[0].data;
                rx_pending.pop_front();
            end
            else
                rx_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end

    // monitor
    always @(posedge clk)
    begin
        frame_result_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (results_due.size() == 0)
                flag_error($sformatf("unexpected result status %0d level %04h",
                                     frame_status, concentration));
            else
            begin
                e = results_due.pop_front();
                if (frame_status !== e.status)
                    flag_error($sformatf("frame_status expected %0d got %0d",
                                         e.status, frame_status));
                if (concentration !== e.level)
                    flag_error($sformatf("concentration expected %04h got %04h",
                                         e.level, concentration));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int          sel;
        int          n;
        logic [7:0]  cmd;
        logic [15:0] level;
        logic [7:0]  b;

        // directed: discarded byte, ok frame with 0xff data bytes inside,
        // wrong command with wrong checksum too, wrong checksum only, ok level 0 frame held until results drain
        queue_byte(8'h00, 1'b0);
        queue_frame(srfr_pkg::CMD_CODE, 16'hFFFF, 1'b1, 1'b0);
        queue_frame(8'hFF, 16'h0000, 1'b0, 1'b0);
        queue_frame(srfr_pkg::CMD_CODE, 16'h1234, 1'b0, 1'b0);
        queue_frame(srfr_pkg::CMD_CODE, 16'h0000, 1'b1, 1'b1);

        while (rx_pending.size() < RANDOM_BYTES)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                n = $urandom_range(9);
                level = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom);
                queue_frame(srfr_pkg::CMD_CODE, level, $urandom_range(9) != 0,
                            $urandom_range(39) == 0);
            end
            else if (sel < 80)
            begin
                cmd = 8'($urandom);
                if (cmd == srfr_pkg::CMD_CODE)
                    cmd = cmd ^ 8'h01;
                queue_frame(cmd, 16'($urandom), 1'($urandom_range(1)), 1'b0);
            end
            else if (sel < 90)
            begin
                // line noise between frames, now and then a stray start byte
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    b = ($urandom_range(7) == 0) ? srfr_pkg::START_BYTE
                                                 : 8'($urandom_range(0, 254));
                    queue_byte(b, 1'b0);
                end
            end
            else
            begin
                // truncated frame, the next one lands misaligned
                queue_byte(srfr_pkg::START_BYTE, 1'b0);
                queue_byte(srfr_pkg::CMD_CODE, 1'b0);
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++)
                    queue_byte(8'($urandom), 1'b0);
            end
        end
        rx_total = rx_pending.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_accepted < rx_total || results_due.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/srfr_pkg.sv
hw/rtl/sensor_response_frame_receiver.sv
hw/rtl/srfr_checker.sv
tb/sv/sensor_response_frame_receiver_tb.sv
